// ----- hw/rtl/oerb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oerb_pkg
// Shared types and constants of the overwriting event ring buffer.
// ----------------------------------------------------------------------------
package oerb_pkg;

	localparam int DEPTH_DEF       = 64;
	localparam int EVENT_WIDTH_DEF = 64;
	localparam int WORD_W          = 64;
	localparam int COUNT_W         = 7;

	typedef enum logic [1:0] {
		MODE_WRITE  = 2'd0,
		MODE_READ   = 2'd1,
		MODE_DUMP   = 2'd2,
		MODE_STATUS = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t               mode;
		logic [WORD_W-1:0]   event_in;
		logic [COUNT_W-1:0]  dump_count;
	} in_req_t;

	typedef struct packed {
		logic [WORD_W-1:0]   event_out;
		logic                ok;
		logic [COUNT_W-1:0]  copied;
		logic                last;
		logic [WORD_W-1:0]   available_count;
		logic [WORD_W-1:0]   total_written;
	} out_rsp_t;

	typedef struct packed {
		logic write;
		logic start;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic out_last;
	} sts_t;

endpackage

// ----- hw/rtl/overwriting_event_ring_buffer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_event_ring_buffer_core
// Circular event trace store with free-running write and read counters.
// ----------------------------------------------------------------------------
// A write request is taken every cycle while no other request is in
// progress, and gives no result; the oldest slot is overwritten silently.
// A read or dump request reads its slot into the single-port slot memory's
// registered read data, prefetched one slot ahead of the result register
// that holds each result; a dump of n events then streams one result per
// cycle while the output is ready, and no request is taken until the final
// result (last set) has been delivered. The slot memory has no reset; only
// slots already written are ever read.
// ----------------------------------------------------------------------------
module overwriting_event_ring_buffer_core #(
	parameter int DEPTH       = oerb_pkg::DEPTH_DEF,
	parameter int EVENT_WIDTH = oerb_pkg::EVENT_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  oerb_pkg::in_req_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output oerb_pkg::out_rsp_t out_data
);

	oerb_pkg::cmd_t cmd;
	oerb_pkg::sts_t sts;

	oerb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.mode      (in_data.mode),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	oerb_datapath #(
		.DEPTH       (DEPTH),
		.EVENT_WIDTH (EVENT_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule

// ----- hw/rtl/oerb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oerb_ctrl
// Request sequencing: accepts requests, schedules result loads and hands
// results to the output channel.
// ----------------------------------------------------------------------------
module oerb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  oerb_pkg::mode_t  mode,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output oerb_pkg::cmd_t   cmd,
	input  oerb_pkg::sts_t   sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;

	always_comb begin
		cmd.write = accept && (mode == oerb_pkg::MODE_WRITE);
		cmd.start = accept && (mode != oerb_pkg::MODE_WRITE);
		cmd.load  = (state_q == ST_LOAD) ||
		            ((state_q == ST_EMIT) && out_ready && !sts.out_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q     <= ST_EMIT;
					out_valid_q <= 1'b1;
				end
				ST_EMIT: begin
					if (out_ready && sts.out_last) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/oerb_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oerb_datapath
// Slot memory, write/read counters, dump pointer and result register.
// ----------------------------------------------------------------------------
module oerb_datapath #(
	parameter int DEPTH       = oerb_pkg::DEPTH_DEF,
	parameter int EVENT_WIDTH = oerb_pkg::EVENT_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  oerb_pkg::in_req_t in_data,
	input  oerb_pkg::cmd_t    cmd,
	output oerb_pkg::sts_t    sts,
	output oerb_pkg::out_rsp_t out_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = oerb_pkg::COUNT_W;
	localparam int WW = oerb_pkg::WORD_W;

	function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] idx);
		idx_inc = (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
	endfunction

	logic [EVENT_WIDTH-1:0] mem [DEPTH];
	logic [EVENT_WIDTH-1:0] rd_data_q;

	logic [WW-1:0] wcnt_q;
	logic [WW-1:0] rcnt_q;
	logic [AW-1:0] widx_q;
	logic [AW-1:0] ridx_q;
	logic [AW-1:0] ptr_q;
	logic [CW-1:0] rem_q;
	logic [CW-1:0] copied_q;
	logic          ok_q;

	oerb_pkg::out_rsp_t out_q;

	logic          nonempty;
	logic [WW-1:0] avail;
	logic [CW-1:0] total;
	logic [CW-1:0] cnt;
	logic [CW-1:0] start_sum;
	logic [AW-1:0] start_idx;
	logic          is_read;
	logic          is_dump;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          more;

	assign nonempty = (wcnt_q > rcnt_q);
	assign avail    = nonempty ? (wcnt_q - rcnt_q) : '0;
	assign total    = (wcnt_q < WW'(DEPTH)) ? wcnt_q[CW-1:0] : CW'(DEPTH);
	assign cnt      = (in_data.dump_count < total) ? in_data.dump_count : total;
	assign start_sum = CW'(widx_q) + CW'(DEPTH) - cnt;
	assign start_idx = (start_sum >= CW'(DEPTH)) ? AW'(start_sum - CW'(DEPTH))
	                                             : AW'(start_sum);
	assign is_read  = (in_data.mode == oerb_pkg::MODE_READ);
	assign is_dump  = (in_data.mode == oerb_pkg::MODE_DUMP);
	assign more     = (rem_q > CW'(1));

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptr_q;
		if (cmd.start) begin
			if (is_read && nonempty) begin
				rd_en   = 1'b1;
				rd_addr = ridx_q;
			end else if (is_dump && (cnt != '0)) begin
				rd_en   = 1'b1;
				rd_addr = start_idx;
			end
		end else if (cmd.load && more) begin
			rd_en   = 1'b1;
			rd_addr = ptr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			mem[widx_q] <= in_data.event_in[EVENT_WIDTH-1:0];
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q <= '0;
			rcnt_q <= '0;
			widx_q <= '0;
			ridx_q <= '0;
			rem_q  <= '0;
		end else begin
			if (cmd.write) begin
				wcnt_q <= wcnt_q + WW'(1);
				widx_q <= idx_inc(widx_q);
			end
			if (cmd.start) begin
				rem_q <= CW'(1);
				if (is_read && nonempty) begin
					rcnt_q <= rcnt_q + WW'(1);
					ridx_q <= idx_inc(ridx_q);
				end else if (is_dump && (cnt != '0)) begin
					rem_q <= cnt;
				end
			end else if (cmd.load && more) begin
				rem_q <= rem_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			ok_q     <= (is_read && nonempty) || (is_dump && (cnt != '0));
			copied_q <= is_dump ? cnt : '0;
			ptr_q    <= idx_inc(start_idx);
		end else if (cmd.load && more) begin
			ptr_q <= idx_inc(ptr_q);
		end
		if (cmd.load) begin
			out_q.event_out       <= ok_q ? WW'(rd_data_q) : '0;
			out_q.ok              <= ok_q;
			out_q.copied          <= copied_q;
			out_q.last            <= !more;
			out_q.available_count <= avail;
			out_q.total_written   <= wcnt_q;
		end
	end

	assign sts.out_last = out_q.last;
	assign out_data     = out_q;

endmodule

// ----- hw/rtl/oerb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oerb_checker
// Port-level checks of the ring buffer core, bound to the top level.
// ----------------------------------------------------------------------------
module oerb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input oerb_pkg::in_req_t  in_data,
	input logic               out_valid,
	input logic               out_ready,
	input oerb_pkg::out_rsp_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.mode == oerb_pkg::MODE_WRITE) |=> !out_valid)
		else $error("write request produced a result");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.ok |-> (out_data.event_out == '0) && out_data.last)
		else $error("failed result not empty or not last");

	a_stream_dump: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> out_data.ok && (out_data.copied != '0))
		else $error("non-final result outside a dump");

endmodule

bind overwriting_event_ring_buffer_core oerb_checker u_oerb_checker (.*);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the overwriting event ring buffer core.
// ----------------------------------------------------------------------------
// Requests go in through a valid/ready port with random gaps. A local model
// of the ring works out the results of each accepted request. A monitor
// compares every delivered result, field by field, with the oldest
// prediction. Test tasks cover the empty buffer, plain write/read, dumps at
// their limits and overrun under a long output stall. A biased random
// traffic phase follows.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int DEPTH         = oerb_pkg::DEPTH_DEF;
	localparam int AW            = $clog2(DEPTH);
	localparam int WORD_W        = oerb_pkg::WORD_W;
	localparam int COUNT_W       = oerb_pkg::COUNT_W;
	localparam int RANDOM_ITEMS  = 165;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 300;
	localparam int CYCLE_LIMIT   = 1000000;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	oerb_pkg::in_req_t  in_data   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	oerb_pkg::out_rsp_t out_data;

	// ring model
	logic [WORD_W-1:0]  trace_mem [DEPTH];
	logic [WORD_W-1:0]  wr_total = '0;
	logic [WORD_W-1:0]  rd_total = '0;
	oerb_pkg::out_rsp_t pending_rsp [$];
	oerb_pkg::out_rsp_t want_rsp;

	int  errors       = 0;
	int  requests     = 0;
	int  results      = 0;
	int  read_hits    = 0;
	int  lapped_reads = 0;
	int  longest_dump = 0;
	int  peak_unread  = 0;
	int  cycles       = 0;
	bit  calm         = 1'b0;

	// output side
	logic        hold_flag = 1'b0;
	logic        hold_seen;
	int unsigned hold_left;
	int unsigned rx_wait;
	int unsigned rx_draw;

	overwriting_event_ring_buffer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #5 clk = ~clk;

	function automatic logic [WORD_W-1:0] unread_now();
		return (wr_total > rd_total) ? wr_total - rd_total : '0;
	endfunction

	function automatic void queue_rsp(logic [WORD_W-1:0] ev, logic ok,
		logic [COUNT_W-1:0] copied, logic last);
		oerb_pkg::out_rsp_t r;
		r.event_out       = ev;
		r.ok              = ok;
		r.copied          = copied;
		r.last            = last;
		r.available_count = unread_now();
		r.total_written   = wr_total;
		pending_rsp.push_back(r);
	endfunction

	function automatic void model_request(oerb_pkg::in_req_t r);
		logic [WORD_W-1:0] span;
		logic [WORD_W-1:0] cnt;
		logic [WORD_W-1:0] base;
		case (r.mode)
			oerb_pkg::MODE_WRITE: begin
				trace_mem[AW'(wr_total % DEPTH)] = r.event_in;
				wr_total = wr_total + WORD_W'(1);
				if (unread_now() > peak_unread)
					peak_unread = int'(unread_now());
			end
			oerb_pkg::MODE_READ: begin
				if (rd_total < wr_total) begin
					if (wr_total - rd_total > DEPTH)
						lapped_reads++;
					read_hits++;
					rd_total = rd_total + WORD_W'(1);
					queue_rsp(trace_mem[AW'((rd_total - WORD_W'(1)) % DEPTH)], 1'b1, '0,
						1'b1);
				end else begin
					queue_rsp('0, 1'b0, '0, 1'b1);
				end
			end
			oerb_pkg::MODE_DUMP: begin
				span = (wr_total < DEPTH) ? wr_total : WORD_W'(DEPTH);
				cnt  = (WORD_W'(r.dump_count) < span) ? WORD_W'(r.dump_count) : span;
				base = wr_total - cnt;
				if (cnt == 0) begin
					queue_rsp('0, 1'b0, '0, 1'b1);
				end else begin
					if (int'(cnt) > longest_dump)
						longest_dump = int'(cnt);
					for (int k = 0; k < int'(cnt); k++)
						queue_rsp(trace_mem[AW'((base + WORD_W'(k)) % DEPTH)], 1'b1,
							cnt[COUNT_W-1:0], k + 1 == int'(cnt));
				end
			end
			default: begin
				queue_rsp('0, 1'b0, '0, 1'b1);
			end
		endcase
	endfunction

	task automatic check_field(string name, logic [WORD_W-1:0] exp_v,
		logic [WORD_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// result check first, then the prediction of the request taken at this edge
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still pending", $time, pending_rsp.size());
			$display("tb_top: errors");
			$finish;
		end
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results++;
				if (pending_rsp.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0h", $time,
						out_data);
					errors++;
				end else begin
					want_rsp = pending_rsp.pop_front();
					check_field("event_out", want_rsp.event_out, out_data.event_out);
					check_field("ok", WORD_W'(want_rsp.ok), WORD_W'(out_data.ok));
					check_field("copied", WORD_W'(want_rsp.copied), WORD_W'(out_data.copied));
					check_field("last", WORD_W'(want_rsp.last), WORD_W'(out_data.last));
					check_field("available_count", want_rsp.available_count,
						out_data.available_count);
					check_field("total_written", want_rsp.total_written,
						out_data.total_written);
				end
			end
			if (in_valid && in_ready) begin
				requests++;
				model_request(in_data);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_seen <= 1'b0;
			hold_left <= 0;
			rx_wait   <= 0;
		end else if (hold_flag != hold_seen) begin
			hold_seen <= hold_flag;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (out_valid && out_ready) begin
			rx_draw = calm ? 0 : $urandom_range(0, 7);
			rx_wait   <= rx_draw;
			out_ready <= (rx_draw == 0);
		end else if (rx_wait != 0) begin
			rx_wait   <= rx_wait - 1;
			out_ready <= (rx_wait == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// returns at the accepting edge with valid still high
	task automatic send_request(oerb_pkg::mode_t m, logic [WORD_W-1:0] ev,
		logic [COUNT_W-1:0] n);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data.mode       <= m;
		in_data.event_in   <= ev;
		in_data.dump_count <= n;
		in_valid           <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// a clock edge passes first so the last request taken is already predicted
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_empty_buffer();
		send_request(oerb_pkg::MODE_READ, {$urandom, $urandom}, 7'd127);
		send_request(oerb_pkg::MODE_DUMP, '0, 7'd0);
		send_request(oerb_pkg::MODE_DUMP, '1, 7'd127);
		send_request(oerb_pkg::MODE_STATUS, '1, 7'd64);
		settle();
	endtask

	task automatic test_write_read();
		send_request(oerb_pkg::MODE_WRITE, '0, 7'd0);
		send_request(oerb_pkg::MODE_WRITE, '1, 7'd127);
		send_request(oerb_pkg::MODE_WRITE, 64'h5555_5555_5555_5555, 7'd1);
		send_request(oerb_pkg::MODE_WRITE, 64'hAAAA_AAAA_AAAA_AAAA, 7'd64);
		send_request(oerb_pkg::MODE_STATUS, '0, 7'd0);
		send_request(oerb_pkg::MODE_READ, '0, 7'd0);
		send_request(oerb_pkg::MODE_READ, '1, 7'd0);
		send_request(oerb_pkg::MODE_DUMP, '0, 7'd0);
		send_request(oerb_pkg::MODE_DUMP, '0, 7'd1);
		send_request(oerb_pkg::MODE_DUMP, '0, 7'd3);
		send_request(oerb_pkg::MODE_DUMP, '0, 7'd127);
		send_request(oerb_pkg::MODE_READ, '0, 7'd0);
		send_request(oerb_pkg::MODE_READ, '0, 7'd0);
		send_request(oerb_pkg::MODE_READ, '0, 7'd0);
		send_request(oerb_pkg::MODE_STATUS, '0, 7'd0);
		settle();
	endtask

	// writer laps the reader while the output is held off
	task automatic test_output_stall();
		calm = 1'b1;
		hold_flag <= ~hold_flag;
		for (int k = 0; k < 70; k++)
			send_request(oerb_pkg::MODE_WRITE, {$urandom, $urandom}, 7'($urandom));
		send_request(oerb_pkg::MODE_DUMP, '0, 7'd64);
		send_request(oerb_pkg::MODE_DUMP, '0, 7'd127);
		send_request(oerb_pkg::MODE_READ, '0, 7'd0);
		send_request(oerb_pkg::MODE_READ, '0, 7'd0);
		send_request(oerb_pkg::MODE_READ, '0, 7'd0);
		send_request(oerb_pkg::MODE_STATUS, '0, 7'd0);
		calm = 1'b0;
		settle();
	endtask

	task automatic test_random_traffic();
		int unsigned pick;
		int unsigned w_lim;
		int unsigned r_lim;
		int unsigned d_lim;
		oerb_pkg::mode_t m;
		logic [WORD_W-1:0] ev;
		logic [COUNT_W-1:0] n;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 40 == 0)
				calm = ($urandom_range(0, 3) == 0);
			case ((i / 32) % 3)
				0: begin w_lim = 75; r_lim = 85; d_lim = 95; end
				1: begin w_lim = 20; r_lim = 75; d_lim = 90; end
				default: begin w_lim = 45; r_lim = 70; d_lim = 90; end
			endcase
			pick = $urandom_range(0, 99);
			m = (pick < w_lim) ? oerb_pkg::MODE_WRITE : (pick < r_lim) ? oerb_pkg::MODE_READ :
				(pick < d_lim) ? oerb_pkg::MODE_DUMP : oerb_pkg::MODE_STATUS;
			case ($urandom_range(0, 9))
				0: ev = '0;
				1: ev = '1;
				default: ev = {$urandom, $urandom};
			endcase
			n = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) :
				7'($urandom_range(0, 6));
			send_request(m, ev, n);
		end
		calm = 1'b0;
		settle();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_buffer();
		test_write_read();
		test_output_stall();
		test_random_traffic();
		$display("tb_top summary: %0d requests, %0d results checked, %0d reads returned data",
			requests, results, read_hits);
		$display("tb_top summary: %0d reads after overrun, longest dump %0d, peak unread %0d",
			lapped_reads, longest_dump, peak_unread);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/oerb_pkg.sv
hw/rtl/oerb_ctrl.sv
hw/rtl/oerb_datapath.sv
hw/rtl/overwriting_event_ring_buffer_core.sv
hw/rtl/oerb_checker.sv
dv/tb_top.sv
